>>> rtl/shfd_pkg.sv
// Shared widths, codes and the mode-to-length table of the sync header deframer.
package shfd_pkg;

	localparam int BYTE_W    = 8;
	localparam int ERR_W     = 3;
	localparam int LEN_W     = 6;
	localparam int WAIT_W    = 4;
	localparam int NIB_W     = 4;
	localparam int MAX_FRAME = 34;

	// request kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// total frame length for each mode nibble, 0 rejects the mode
	function automatic logic [LEN_W-1:0] len_table(input logic [NIB_W-1:0] nib);
		logic [LEN_W-1:0] len;
		case (nib)
			4'h1: len = 6'd26;
			4'h2: len = 6'd4;
			4'h3: len = 6'd34;
			4'h5: len = 6'd34;
			4'h6: len = 6'd34;
			4'h8: len = 6'd25;
			4'h9: len = 6'd25;
			4'hA: len = 6'd25;
			4'hB: len = 6'd31;
			4'hC: len = 6'd28;
			4'hF: len = 6'd4;
			default: len = 6'd0;
		endcase
		return len;
	endfunction

endpackage

>>> rtl/shfd_if.sv
// Valid/ready channel interfaces for the deframer request and response beats.
interface shfd_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [shfd_pkg::BYTE_W-1:0]   rx_byte;
	logic [shfd_pkg::ERR_W-1:0]    rx_error_bits;

	modport source (output valid, kind, rx_byte, rx_error_bits, input ready);
	modport sink   (input valid, kind, rx_byte, rx_error_bits, output ready);
endinterface

interface shfd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [shfd_pkg::BYTE_W-1:0]   frame_byte;
	logic [shfd_pkg::LEN_W-1:0]    frame_length;
	logic                          last_byte;
	logic                          no_frame;
	logic [shfd_pkg::WAIT_W-1:0]   frames_waiting;

	modport source (output valid, frame_byte, frame_length, last_byte, no_frame,
		frames_waiting, input ready);
	modport sink   (input valid, frame_byte, frame_length, last_byte, no_frame,
		frames_waiting, output ready);
endinterface

>>> rtl/shfd_store.sv
// Single-port frame byte store with registered read data.
module shfd_store #(
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [ADDR_W-1:0]           addr,
	input  logic [shfd_pkg::BYTE_W-1:0] wdata,
	output logic [shfd_pkg::BYTE_W-1:0] rdata
);

	logic [shfd_pkg::BYTE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

>>> rtl/sync_header_frame_deframer.sv
// Top level: sync header hunt, frame slot ring and byte-wise frame readout.
//
// Usage:
//   req channel: one beat per item. kind 0 hands in a received UART byte
//   with its error flags; kind 1 asks for the oldest complete frame.
//   rsp channel: a read yields one beat per stored frame byte (two sync
//   bytes, the mode nibble, then data), last_byte on the final one, or a
//   single no_frame beat when the ring is empty.
//   cfg_we/cfg_wdata load the sync byte value; write only while idle.
// Sequencing:
//   A received byte is taken in S_IDLE; an accepted mode byte then holds
//   the block in S_HDR1 and S_HDR2, since the two sync bytes and the nibble
//   go through the one store write port. A read latches the slot, then
//   goes through S_RD_ISSUE (store read) and S_RD_LOAD (output register
//   load) per frame byte, or S_EMPTY when empty; req.ready is low meanwhile.
// Reset: hunt restarts at first sync byte, ring empty, sync byte 0xFF.
//   The byte store is not cleared; only written entries are ever read.
// Stall: the response register holds its beat while rsp.ready is low and
//   the readout sequencer waits on it; req.ready returns once the last beat
//   is in the register.
module sync_header_frame_deframer #(
	parameter int SLOTS      = 2,
	parameter int SLOT_BYTES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [shfd_pkg::BYTE_W-1:0] cfg_wdata,
	shfd_req_if.sink                    req,
	shfd_rsp_if.source                  rsp
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int DEPTH  = SLOTS * SLOT_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = shfd_pkg::LEN_W;
	localparam int BYTE_W = shfd_pkg::BYTE_W;

	typedef enum logic [1:0] {
		H_SYNC1,
		H_SYNC2,
		H_MODE,
		H_RECV
	} hunt_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR1,
		S_HDR2,
		S_RD_ISSUE,
		S_RD_LOAD,
		S_EMPTY
	} seq_t;

	seq_t                    seq_q;
	hunt_t                   hunt_q;
	logic [BYTE_W-1:0]       sync_q;
	logic [SLOT_W-1:0]       ws_q;
	logic [SLOT_W-1:0]       rs_q;
	logic [LEN_W-1:0]        byte_idx_q;
	logic [LEN_W-1:0]        frame_len_q;
	logic [shfd_pkg::NIB_W-1:0] nib_q;
	logic [LEN_W-1:0]        slot_len_q [SLOTS];
	logic [SLOT_W-1:0]       rd_slot_q;
	logic [LEN_W-1:0]        rd_idx_q;
	logic [LEN_W-1:0]        rd_len_q;
	logic [shfd_pkg::WAIT_W-1:0] wait_q;

	logic                    out_valid_q;
	logic [BYTE_W-1:0]       out_byte_q;
	logic [LEN_W-1:0]        out_len_q;
	logic                    out_last_q;
	logic                    out_none_q;
	logic [shfd_pkg::WAIT_W-1:0] out_wait_q;

	logic                    accept;
	logic                    out_free;
	logic                    out_load;
	logic                    rx_err;
	logic [LEN_W-1:0]        mode_len;
	logic [LEN_W-1:0]        byte_nxt;
	logic [LEN_W-1:0]        rd_idx_nxt;
	logic [SLOT_W-1:0]       ws_nxt;
	logic [SLOT_W-1:0]       rs_nxt;
	logic [SLOT_W:0]         wait_c;
	logic [SLOT_W-1:0]       mem_slot;
	logic [LEN_W-1:0]        mem_idx;
	logic [ADDR_W-1:0]       mem_addr;
	logic                    mem_we;
	logic                    mem_re;
	logic [BYTE_W-1:0]       mem_wdata;
	logic [BYTE_W-1:0]       mem_rdata;

	assign req.ready  = (seq_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign out_free   = !out_valid_q || rsp.ready;
	// a beat goes into the response register this cycle
	assign out_load   = ((seq_q == S_RD_LOAD) || (seq_q == S_EMPTY)) && out_free;
	assign rx_err     = (req.rx_error_bits != '0);
	assign mode_len   = shfd_pkg::len_table(req.rx_byte[shfd_pkg::NIB_W-1:0]);
	assign byte_nxt   = byte_idx_q + 1'b1;
	assign rd_idx_nxt = rd_idx_q + 1'b1;
	assign ws_nxt     = (ws_q == SLOT_W'(SLOTS - 1)) ? '0 : ws_q + 1'b1;
	assign rs_nxt     = (rs_q == SLOT_W'(SLOTS - 1)) ? '0 : rs_q + 1'b1;

	// frames left after this read, modulo the ring size
	always_comb begin
		if (ws_q >= rs_nxt) begin
			wait_c = {1'b0, ws_q} - {1'b0, rs_nxt};
		end else begin
			wait_c = {1'b0, ws_q} + (SLOT_W+1)'(SLOTS) - {1'b0, rs_nxt};
		end
	end

	// one store port, shared by header writes, data writes and readout
	always_comb begin
		mem_slot  = ws_q;
		mem_idx   = byte_idx_q;
		mem_wdata = req.rx_byte;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		case (seq_q)
			S_HDR1: begin
				mem_idx   = LEN_W'(1);
				mem_wdata = sync_q;
				mem_we    = 1'b1;
			end
			S_HDR2: begin
				mem_idx   = LEN_W'(2);
				mem_wdata = BYTE_W'(nib_q);
				mem_we    = 1'b1;
			end
			S_RD_ISSUE: begin
				mem_slot = rd_slot_q;
				mem_idx  = rd_idx_q;
				mem_re   = 1'b1;
			end
			S_IDLE: begin
				if (hunt_q == H_MODE) begin
					mem_idx   = '0;
					mem_wdata = sync_q;
				end
				mem_we = accept && (req.kind == shfd_pkg::KIND_BYTE) && !rx_err
					&& ((hunt_q == H_RECV) || ((hunt_q == H_MODE) && (mode_len != '0)));
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_addr = ADDR_W'(mem_slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(mem_idx);

	shfd_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= S_IDLE;
			hunt_q      <= H_SYNC1;
			sync_q      <= 8'hFF;
			ws_q        <= '0;
			rs_q        <= '0;
			byte_idx_q  <= '0;
			frame_len_q <= '0;
			nib_q       <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_len_q[i] <= '0;
			end
			rd_slot_q   <= '0;
			rd_idx_q    <= '0;
			rd_len_q    <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_len_q   <= '0;
			out_last_q  <= 1'b0;
			out_none_q  <= 1'b0;
			out_wait_q  <= '0;
		end else begin
			if (cfg_we) begin
				sync_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (seq_q)
				S_IDLE: begin
					if (accept && (req.kind == shfd_pkg::KIND_READ)) begin
						if (rs_q == ws_q) begin
							seq_q <= S_EMPTY;
						end else begin
							rd_slot_q <= rs_q;
							rd_len_q  <= slot_len_q[rs_q];
							rd_idx_q  <= '0;
							rs_q      <= rs_nxt;
							wait_q    <= shfd_pkg::WAIT_W'(wait_c);
							seq_q     <= S_RD_ISSUE;
						end
					end else if (accept) begin
						if (rx_err) begin
							byte_idx_q <= '0;
							hunt_q     <= H_SYNC1;
						end else begin
							case (hunt_q)
								H_SYNC2: begin
									hunt_q <= (req.rx_byte == sync_q) ? H_MODE : H_SYNC1;
								end
								H_MODE: begin
									if (mode_len == '0) begin
										hunt_q <= H_SYNC1;
									end else begin
										frame_len_q <= mode_len;
										nib_q       <= req.rx_byte[shfd_pkg::NIB_W-1:0];
										byte_idx_q  <= LEN_W'(3);
										hunt_q      <= H_RECV;
										seq_q       <= S_HDR1;
									end
								end
								H_RECV: begin
									if (byte_nxt >= frame_len_q) begin
										slot_len_q[ws_q] <= byte_nxt;
										ws_q             <= ws_nxt;
										byte_idx_q       <= '0;
										hunt_q           <= H_SYNC1;
									end else begin
										byte_idx_q <= byte_nxt;
									end
								end
								default: begin
									if (req.rx_byte == sync_q) begin
										hunt_q <= H_SYNC2;
									end
								end
							endcase
						end
					end
				end
				S_HDR1: begin
					seq_q <= S_HDR2;
				end
				S_HDR2: begin
					seq_q <= S_IDLE;
				end
				S_RD_ISSUE: begin
					seq_q <= S_RD_LOAD;
				end
				S_RD_LOAD: begin
					if (out_free) begin
						out_byte_q  <= mem_rdata;
						out_len_q   <= rd_len_q;
						out_last_q  <= (rd_idx_nxt == rd_len_q);
						out_none_q  <= 1'b0;
						out_wait_q  <= wait_q;
						rd_idx_q    <= rd_idx_nxt;
						seq_q       <= (rd_idx_nxt == rd_len_q) ? S_IDLE : S_RD_ISSUE;
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						out_byte_q  <= '0;
						out_len_q   <= '0;
						out_last_q  <= 1'b1;
						out_none_q  <= 1'b1;
						out_wait_q  <= '0;
						seq_q       <= S_IDLE;
					end
				end
				default: begin
					seq_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.frame_byte     = out_byte_q;
	assign rsp.frame_length   = out_len_q;
	assign rsp.last_byte      = out_last_q;
	assign rsp.no_frame       = out_none_q;
	assign rsp.frames_waiting = out_wait_q;

endmodule

>>> rtl/shfd_checker.sv
// Port-level checks of the deframer, bound to the top level.
module shfd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          req_kind,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [shfd_pkg::BYTE_W-1:0]   rsp_frame_byte,
	input logic [shfd_pkg::LEN_W-1:0]    rsp_frame_length,
	input logic                          rsp_last_byte,
	input logic                          rsp_no_frame
);

	// a stalled beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
			&& $stable(rsp_last_byte))
		else $error("response beat changed while stalled");

	// a read request always starts a readout, with req.ready low after it
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_kind == shfd_pkg::KIND_READ) |=> !req_ready)
		else $error("request taken right after a read");

	// an empty result is a single closing beat of length zero
	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_no_frame |-> rsp_last_byte && (rsp_frame_length == '0))
		else $error("malformed empty result");

	// no frame longer than the table allows
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_frame_length <= shfd_pkg::LEN_W'(shfd_pkg::MAX_FRAME))
		else $error("frame length out of range");

endmodule

bind sync_header_frame_deframer shfd_checker u_shfd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_kind         (req.kind),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_frame_byte   (rsp.frame_byte),
	.rsp_frame_length (rsp.frame_length),
	.rsp_last_byte    (rsp.last_byte),
	.rsp_no_frame     (rsp.no_frame)
);

>>> verif/tb_top.sv
// Testbench for the sync header deframer: stimulus, beat-level predictor and response checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTE_W      = shfd_pkg::BYTE_W;
	localparam int ERR_W       = shfd_pkg::ERR_W;
	localparam int LEN_W       = shfd_pkg::LEN_W;
	localparam int WAIT_W      = shfd_pkg::WAIT_W;
	localparam int NIB_W       = shfd_pkg::NIB_W;
	localparam int MAX_FRAME   = shfd_pkg::MAX_FRAME;

	localparam int SLOTS       = 2;
	localparam int SLOT_BYTES  = 64;
	localparam int IDLE_PCT    = 18;
	localparam int SETTLE      = 12;      // covers the header store that follows a mode byte
	localparam int CYCLE_LIMIT = 400000;

	// hunt codes; any other code acts as the first sync wait
	typedef enum logic [2:0] {
		HUNT_SYNC1 = 3'd0,
		HUNT_SYNC2 = 3'd1,
		HUNT_MODE  = 3'd2,
		HUNT_BODY  = 3'd4
	} hunt_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic [LEN_W-1:0]  frame_length;
		logic              last_byte;
		logic              no_frame;
		logic [WAIT_W-1:0] frames_waiting;
	} rsp_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [BYTE_W-1:0] cfg_wdata;

	shfd_req_if req_ch ();
	shfd_rsp_if rsp_ch ();

	sync_header_frame_deframer #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor state: hunt FSM, slot ring and byte store
	// ---------------------------------------------------------------
	hunt_t             hunt_q;
	int unsigned       wr_slot;
	int unsigned       rd_slot;
	logic [LEN_W-1:0]  body_idx;
	logic [LEN_W-1:0]  slot_len [SLOTS];
	logic [BYTE_W-1:0] slot_mem [SLOTS*SLOT_BYTES];
	logic [BYTE_W-1:0] sync_val;

	rsp_beat_t pending_beats[$];   // beats the block still owes us, oldest first

	int  mismatches = 0;
	int  beats_seen = 0;
	int  items_sent = 0;
	int  cycles     = 0;
	bit  steady_flow = 1'b0;       // no idling on either side while set

	// total frame length per mode nibble; 0 means the mode is rejected
	function automatic int mode_length(input logic [NIB_W-1:0] nib);
		case (nib)
			4'h1: return 26;
			4'h2: return 4;
			4'h3: return 34;
			4'h5: return 34;
			4'h6: return 34;
			4'h8: return 25;
			4'h9: return 25;
			4'hA: return 25;
			4'hB: return 31;
			4'hC: return 28;
			4'hF: return 4;
			default: return 0;
		endcase
	endfunction

	task automatic clear_model();
		hunt_q   = HUNT_SYNC1;
		wr_slot  = 0;
		rd_slot  = 0;
		body_idx = '0;
		sync_val = 8'hFF;
		for (int s = 0; s < SLOTS; s++) slot_len[s] = '0;
		for (int i = 0; i < SLOTS*SLOT_BYTES; i++) slot_mem[i] = '0;
	endtask

	// received byte: advance the hunt and fill the write slot
	task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic [ERR_W-1:0] err);
		int unsigned ws;
		logic [NIB_W-1:0] nib;
		ws = wr_slot;
		if (err != '0) begin
			// any error flag drops the partial frame and restarts the hunt
			body_idx     = '0;
			slot_len[ws] = '0;
			hunt_q       = HUNT_SYNC1;
			return;
		end
		case (hunt_q)
			HUNT_SYNC2: begin
				hunt_q = (b == sync_val) ? HUNT_MODE : HUNT_SYNC1;
			end
			HUNT_MODE: begin
				nib = b[NIB_W-1:0];
				if (mode_length(nib) == 0) begin
					hunt_q = HUNT_SYNC1;
				end else begin
					// header goes in as sync, sync, bare nibble
					slot_mem[ws*SLOT_BYTES + 0] = sync_val;
					slot_mem[ws*SLOT_BYTES + 1] = sync_val;
					slot_mem[ws*SLOT_BYTES + 2] = {4'h0, nib};
					slot_len[ws] = 6'd3;
					body_idx     = 6'd3;
					hunt_q       = HUNT_BODY;
				end
			end
			HUNT_BODY: begin
				if (body_idx < SLOT_BYTES)
					slot_mem[ws*SLOT_BYTES + body_idx] = b;
				slot_len[ws] = slot_len[ws] + 6'd1;
				body_idx     = body_idx + 6'd1;
				nib = slot_mem[ws*SLOT_BYTES + 2][NIB_W-1:0];
				if (nib != '0 && slot_len[ws] >= mode_length(nib)) begin
					// frame complete: move on, no guard against lapping the reader
					ws           = (ws + 1) % SLOTS;
					wr_slot      = ws;
					body_idx     = '0;
					slot_len[ws] = '0;
					hunt_q       = HUNT_SYNC1;
				end
			end
			default: begin
				if (b == sync_val) hunt_q = HUNT_SYNC2;
			end
		endcase
	endtask

	// read request: queue the beats of the oldest complete frame
	task automatic read_out_frame();
		int unsigned rs, ws, len, n, waiting;
		rsp_beat_t beat;
		rs = rd_slot;
		ws = wr_slot;
		if (rs == ws) begin
			beat = '{frame_byte: '0, frame_length: '0, last_byte: 1'b1,
				no_frame: 1'b1, frames_waiting: '0};
			pending_beats.push_back(beat);
			return;
		end
		len = slot_len[rs];
		n   = len;
		if (n > MAX_FRAME) n = MAX_FRAME;
		if (n > SLOT_BYTES) n = SLOT_BYTES;
		rd_slot = (rs + 1) % SLOTS;
		waiting = (ws + SLOTS - rd_slot) % SLOTS;
		if (n == 0) begin
			beat = '{frame_byte: '0, frame_length: len[LEN_W-1:0], last_byte: 1'b1,
				no_frame: 1'b0, frames_waiting: waiting[WAIT_W-1:0]};
			pending_beats.push_back(beat);
			return;
		end
		for (int k = 0; k < n; k++) begin
			beat.frame_byte     = slot_mem[rs*SLOT_BYTES + k];
			beat.frame_length   = len[LEN_W-1:0];
			beat.last_byte      = (k == n - 1);
			beat.no_frame       = 1'b0;
			beat.frames_waiting = waiting[WAIT_W-1:0];
			pending_beats.push_back(beat);
		end
	endtask

	// ---------------------------------------------------------------
	// Request driver
	// ---------------------------------------------------------------
	// One beat on req. Valid is left high on return; the next call either
	// replaces the payload or drops valid for an idle cycle.
	task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b,
		input logic [ERR_W-1:0] err);
		@(negedge clk);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.kind          <= kind;
		req_ch.rx_byte       <= b;
		req_ch.rx_error_bits <= err;
		do @(posedge clk); while (!req_ch.ready);
		// accepted at this edge; predict right away
		if (kind == shfd_pkg::KIND_READ)
			read_out_frame();
		else
			deframe_byte(b, err);
		items_sent++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_item(shfd_pkg::KIND_BYTE, b, '0);
	endtask

	// read with junk in the unused fields
	task automatic send_read();
		send_item(shfd_pkg::KIND_READ, BYTE_W'($urandom), ERR_W'($urandom));
	endtask

	// drop valid, let every owed beat arrive, then let the block settle
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_sync(input logic [BYTE_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sync_val   = v;
	endtask

	function automatic logic [NIB_W-1:0] pick_mode();
		logic [NIB_W-1:0] nib;
		// short frames half the time, so reads come often
		if ($urandom_range(1)) return $urandom_range(1) ? 4'h2 : 4'hF;
		do nib = NIB_W'($urandom); while (mode_length(nib) == 0);
		return nib;
	endfunction

	// whole frame, or one cut short by an error beat at a random spot
	task automatic send_frame(input logic [NIB_W-1:0] nib, input bit faulty);
		int len, cut;
		len = mode_length(nib);
		cut = $urandom_range(len - 1);
		for (int k = 0; k < len; k++) begin
			if (faulty && k == cut) begin
				send_item(shfd_pkg::KIND_BYTE, BYTE_W'($urandom),
					ERR_W'($urandom_range(7, 1)));
				return;
			end
			if (k < 2)
				send_byte(sync_val);
			else if (k == 2)
				send_byte({4'($urandom), nib});
			else
				send_byte(BYTE_W'($urandom));
		end
	endtask

	// ---------------------------------------------------------------
	// Response side: random backpressure and the beat checker
	// ---------------------------------------------------------------
	always @(negedge clk)
		rsp_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch beat %0d %s: got 0x%0h want 0x%0h", beats_seen, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_beat_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected beat", rsp_ch.frame_byte, 0);
			end else begin
				want = pending_beats.pop_front();
				if (rsp_ch.frame_byte !== want.frame_byte)
					report_mismatch("frame_byte", rsp_ch.frame_byte, want.frame_byte);
				if (rsp_ch.frame_length !== want.frame_length)
					report_mismatch("frame_length", rsp_ch.frame_length, want.frame_length);
				if (rsp_ch.last_byte !== want.last_byte)
					report_mismatch("last_byte", rsp_ch.last_byte, want.last_byte);
				if (rsp_ch.no_frame !== want.no_frame)
					report_mismatch("no_frame", rsp_ch.no_frame, want.no_frame);
				if (rsp_ch.frames_waiting !== want.frames_waiting)
					report_mismatch("frames_waiting", rsp_ch.frames_waiting,
						want.frames_waiting);
			end
			beats_seen++;
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL sync_header_frame_deframer");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// read with nothing stored gives the single no_frame beat
	task automatic test_empty_read();
		send_read();
	endtask

	// shortest frame, mode byte with junk upper nibble, data at the low extreme
	task automatic test_min_frame();
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hF2);
		send_byte(8'h00);
		send_read();
	endtask

	// mode nibble with a zero table length sends the hunt back to the start
	task automatic test_rejected_mode();
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
	endtask

	// error flags in both sync phases and the body; flagged byte equals sync and must still be dropped
	task automatic test_error_abort();
		send_item(shfd_pkg::KIND_BYTE, 8'hFF, 3'b001);
		send_byte(8'hFF);
		send_item(shfd_pkg::KIND_BYTE, 8'hFF, 3'b010);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h0F);
		send_item(shfd_pkg::KIND_BYTE, 8'hFF, 3'b100);
		send_read();
	endtask

	// two frames with no read in between: writer laps reader, ring looks empty
	task automatic test_overrun();
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h0F);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h02);
		send_byte(8'h5A);
		send_read();
	endtask

	// mostly well-formed frames with random content, plus noise and broken headers
	task automatic test_random_traffic(input int n_items);
		int start, r;
		logic [BYTE_W-1:0] b;
		logic [NIB_W-1:0] nib;
		start = items_sent;
		while (items_sent - start < n_items) begin
			r = $urandom_range(99);
			if (r < 60) begin
				send_frame(pick_mode(), $urandom_range(99) < 8);
				if ($urandom_range(99) < 80) send_read();
			end else if (r < 70) begin
				send_read();
			end else if (r < 80) begin
				// line noise, sometimes flagged
				send_item(shfd_pkg::KIND_BYTE, BYTE_W'($urandom),
					($urandom_range(3) == 0) ? ERR_W'($urandom) : '0);
			end else if (r < 87) begin
				do nib = NIB_W'($urandom); while (mode_length(nib) != 0);
				send_byte(sync_val);
				send_byte(sync_val);
				send_byte({4'($urandom), nib});
			end else if (r < 93) begin
				// second sync byte wrong
				do b = BYTE_W'($urandom); while (b == sync_val);
				send_byte(sync_val);
				send_byte(b);
			end else begin
				send_frame(pick_mode(), 1'b0);
				send_frame(pick_mode(), 1'b0);
				send_read();
				send_read();
			end
		end
	endtask

	// walk through sync byte settings, extremes included, with one run at full flow
	task automatic test_sync_settings();
		set_sync(8'h00);
		test_random_traffic(105);
		set_sync(8'hA5);
		test_random_traffic(105);
		set_sync(BYTE_W'($urandom));
		steady_flow = 1'b1;
		test_random_traffic(100);
		wait_idle();
		steady_flow = 1'b0;
		set_sync(8'hFF);
		test_random_traffic(105);
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		req_ch.valid         = 1'b0;
		req_ch.kind          = shfd_pkg::KIND_BYTE;
		req_ch.rx_byte       = '0;
		req_ch.rx_error_bits = '0;
		rsp_ch.ready         = 1'b0;
		clear_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_read();
		test_min_frame();
		test_rejected_mode();
		test_error_abort();
		test_overrun();
		test_sync_settings();

		wait_idle();
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("PASS sync_header_frame_deframer");
		else
			$display("FAIL sync_header_frame_deframer");
		$finish;
	end

endmodule

>>> sync_header_frame_deframer.f
rtl/shfd_pkg.sv
rtl/shfd_if.sv
rtl/shfd_store.sv
rtl/sync_header_frame_deframer.sv
rtl/shfd_checker.sv
verif/tb_top.sv
